// ----- src/dnsttl_pkg.sv -----
// Shared constants for the DNS answer minimum-TTL scanner.
// Holds register indexes, reset values, result codes and header offsets.
// No dependencies.
`default_nettype none

package dnsttl_pkg;

    // Widths of the item fields and configuration data.
    localparam int unsigned TTL_W  = 17;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OC_W   = 3;
    localparam int unsigned IDX_W  = 2;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_TTL_FLOOR    = 2'd0,
        REG_TTL_CAP      = 2'd1,
        REG_FALLBACK_TTL = 2'd2,
        REG_NXDOMAIN_TTL = 2'd3
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [TTL_W-1:0] FLOOR_RESET    = 17'd10;
    localparam logic [TTL_W-1:0] CAP_RESET      = 17'd86400;
    localparam logic [TTL_W-1:0] FALLBACK_RESET = 17'd60;
    localparam logic [TTL_W-1:0] NXDOMAIN_RESET = 17'd60;

    // Result codes carried on the outcome field.
    localparam logic [OC_W-1:0] OC_ANSWERS   = 3'd0;
    localparam logic [OC_W-1:0] OC_SHORT_HDR = 3'd1;
    localparam logic [OC_W-1:0] OC_NXDOMAIN  = 3'd2;
    localparam logic [OC_W-1:0] OC_NO_ANSWER = 3'd3;
    localparam logic [OC_W-1:0] OC_TRUNCATED = 3'd4;

    // Header byte offsets and protocol constants.
    localparam logic [3:0] HDR_RCODE    = 4'd3;
    localparam logic [3:0] HDR_QD_HI    = 4'd4;
    localparam logic [3:0] HDR_QD_LO    = 4'd5;
    localparam logic [3:0] HDR_AN_HI    = 4'd6;
    localparam logic [3:0] HDR_AN_LO    = 4'd7;
    localparam logic [3:0] HDR_LAST     = 4'd11;
    localparam logic [3:0] RCODE_NXDOMAIN = 4'd3;
    localparam logic [1:0] PTR_MARK     = 2'b11;

    // Offsets inside the 10-byte fixed part of a resource record.
    localparam logic [3:0] FIX_TTL_FIRST = 4'd4;
    localparam logic [3:0] FIX_TTL_LAST  = 4'd7;
    localparam logic [3:0] FIX_LEN_FIRST = 4'd8;
    localparam logic [3:0] FIX_LAST      = 4'd9;

    // Bytes to skip after a question name: type and class, plus one pointer byte.
    localparam logic [15:0] QTAIL_SKIP     = 16'd4;
    localparam logic [15:0] QTAIL_PTR_SKIP = 16'd5;

endpackage : dnsttl_pkg

`default_nettype wire

// ----- src/dns_answer_min_ttl_scanner_unit.sv -----
// Top level of the DNS answer minimum-TTL scanner: byte parser and output stage.
// Depends on dnsttl_pkg for codes, offsets and register reset values.
//
// The unit takes one message byte per clock while in_ready is high and gives
// one TTL item for each message, registered when the byte flagged last_byte is
// accepted. Every byte updates a handful of counters and one 32-bit TTL compare,
// so the sustained rate is one byte per clock. Results pass through an output
// register backed by a one-entry skid register; bytes keep flowing while a
// result waits, and in_ready falls only when both entries are full.
`default_nettype none

module dns_answer_min_ttl_scanner_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Byte input channel.
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [dnsttl_pkg::BYTE_W-1:0]   msg_byte,
    input  wire logic                            last_byte,
    // Result channel.
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [dnsttl_pkg::TTL_W-1:0]         ttl_seconds,
    output logic [dnsttl_pkg::OC_W-1:0]          outcome,
    // Configuration write port.
    input  wire logic                            cfg_we,
    input  wire logic [dnsttl_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [dnsttl_pkg::TTL_W-1:0]    cfg_data
);

    import dnsttl_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_QNAME   = 3'd1,
        PH_ANAME   = 3'd2,
        PH_AFIXED  = 3'd3,
        PH_ADATA   = 3'd4,
        PH_DONE_OK = 3'd5,
        PH_DONE_NX = 3'd6,
        PH_DONE_ER = 3'd7
    } phase_t;

    // Configuration registers.
    logic [TTL_W-1:0] ttl_floor_reg;
    logic [TTL_W-1:0] ttl_cap_reg;
    logic [TTL_W-1:0] fallback_reg;
    logic [TTL_W-1:0] nxdomain_reg;

    // Parser state.
    phase_t      phase_reg,        phase_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic [3:0]  rcode_reg,        rcode_next;
    logic [15:0] questions_reg,    questions_next;
    logic [15:0] answers_reg,      answers_next;
    logic [15:0] skip_reg,         skip_next;
    logic [3:0]  fixed_index_reg,  fixed_index_next;
    logic [31:0] record_ttl_reg,   record_ttl_next;
    logic [TTL_W-1:0] min_ttl_reg, min_ttl_next;
    logic [15:0] data_len_reg,     data_len_next;

    // Output register and skid register.
    logic             out_valid_reg;
    logic [TTL_W-1:0] out_ttl_reg;
    logic [OC_W-1:0]  out_oc_reg;
    logic             skid_valid_reg;
    logic [TTL_W-1:0] skid_ttl_reg;
    logic [OC_W-1:0]  skid_oc_reg;

    // Per-byte working signals.
    logic             in_fire;
    logic             produce;
    logic             out_take;
    logic             rec_open;
    logic             rec_done;
    logic [15:0]      skip_dec;
    logic [15:0]      answers_dec;
    logic [TTL_W-1:0] clamp_lo;
    logic [TTL_W-1:0] clamp_min;
    logic [TTL_W-1:0] res_ttl;
    logic [OC_W-1:0]  res_oc;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign produce   = in_fire && last_byte;
    assign out_take  = out_valid_reg && out_ready;
    assign out_valid   = out_valid_reg;
    assign ttl_seconds = out_ttl_reg;
    assign outcome     = out_oc_reg;

    assign skip_dec    = skip_reg - 16'd1;
    assign answers_dec = answers_reg - 16'd1;

    // Configuration writes; an index with no register behind it is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_floor_reg <= FLOOR_RESET;
            ttl_cap_reg   <= CAP_RESET;
            fallback_reg  <= FALLBACK_RESET;
            nxdomain_reg  <= NXDOMAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TTL_FLOOR:    ttl_floor_reg <= cfg_data;
                REG_TTL_CAP:      ttl_cap_reg   <= cfg_data;
                REG_FALLBACK_TTL: fallback_reg  <= cfg_data;
                REG_NXDOMAIN_TTL: nxdomain_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Parser: next state for the byte on the input.
    always_comb
    begin
        phase_next        = phase_reg;
        header_index_next = header_index_reg;
        rcode_next        = rcode_reg;
        questions_next    = questions_reg;
        answers_next      = answers_reg;
        skip_next         = skip_reg;
        fixed_index_next  = fixed_index_reg;
        record_ttl_next   = record_ttl_reg;
        min_ttl_next      = min_ttl_reg;
        data_len_next     = data_len_reg;
        rec_open          = 1'b0;
        rec_done          = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                case (header_index_reg)
                    HDR_RCODE: rcode_next     = msg_byte[3:0];
                    HDR_QD_HI: questions_next = {msg_byte, 8'h00};
                    HDR_QD_LO: questions_next = questions_reg | {8'h00, msg_byte};
                    HDR_AN_HI: answers_next   = {msg_byte, 8'h00};
                    HDR_AN_LO: answers_next   = answers_reg | {8'h00, msg_byte};
                    default:   ;
                endcase
                if (header_index_reg >= HDR_LAST)
                begin
                    // Header complete: pick the verdict or the first name to walk.
                    min_ttl_next = ttl_cap_reg;
                    skip_next    = 16'd0;
                    if (rcode_reg == RCODE_NXDOMAIN)
                        phase_next = PH_DONE_NX;
                    else if (rcode_reg != 4'd0 || answers_reg == 16'd0)
                        phase_next = PH_DONE_ER;
                    else if (questions_reg != 16'd0)
                        phase_next = PH_QNAME;
                    else
                        phase_next = PH_ANAME;
                end
                else
                begin
                    header_index_next = header_index_reg + 4'd1;
                end
            end

            PH_QNAME:
            begin
                if (skip_reg != 16'd0)
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0 && questions_reg == 16'd0)
                        phase_next = PH_ANAME;
                end
                else if (msg_byte == 8'h00)
                begin
                    questions_next = questions_reg - 16'd1;
                    skip_next      = QTAIL_SKIP;
                end
                else if (msg_byte[7:6] == PTR_MARK)
                begin
                    questions_next = questions_reg - 16'd1;
                    skip_next      = QTAIL_PTR_SKIP;
                end
                else
                begin
                    skip_next = {8'h00, msg_byte};
                end
            end

            PH_ANAME:
            begin
                rec_open = 1'b1;
                if (skip_reg != 16'd0)
                begin
                    skip_next = skip_dec;
                end
                else if (msg_byte == 8'h00)
                begin
                    phase_next       = PH_AFIXED;
                    fixed_index_next = 4'd0;
                end
                else if (msg_byte[7:6] == PTR_MARK)
                begin
                    // The pointer's second byte is skipped inside the fixed part.
                    skip_next        = 16'd1;
                    phase_next       = PH_AFIXED;
                    fixed_index_next = 4'd0;
                end
                else
                begin
                    skip_next = {8'h00, msg_byte};
                end
            end

            PH_AFIXED:
            begin
                rec_open = 1'b1;
                if (skip_reg != 16'd0)
                begin
                    skip_next = skip_dec;
                end
                else
                begin
                    if (fixed_index_reg >= FIX_TTL_FIRST && fixed_index_reg <= FIX_TTL_LAST)
                        record_ttl_next = {record_ttl_reg[23:0], msg_byte};
                    else if (fixed_index_reg >= FIX_LEN_FIRST)
                        data_len_next = {data_len_reg[7:0], msg_byte};

                    if (fixed_index_reg >= FIX_LAST)
                    begin
                        // Record header complete: fold its TTL into the minimum.
                        rec_done         = 1'b1;
                        fixed_index_next = 4'd0;
                        answers_next     = answers_dec;
                        if (record_ttl_reg < {15'd0, min_ttl_reg})
                            min_ttl_next = record_ttl_reg[TTL_W-1:0];
                        if (answers_dec == 16'd0)
                        begin
                            phase_next = PH_DONE_OK;
                            skip_next  = 16'd0;
                        end
                        else if (data_len_next == 16'd0)
                        begin
                            phase_next = PH_ANAME;
                        end
                        else
                        begin
                            skip_next  = data_len_next;
                            phase_next = PH_ADATA;
                        end
                    end
                    else
                    begin
                        fixed_index_next = fixed_index_reg + 4'd1;
                    end
                end
            end

            PH_ADATA:
            begin
                if (skip_reg != 16'd0)
                    skip_next = skip_dec;
                if (skip_next == 16'd0)
                    phase_next = PH_ANAME;
            end

            default:
            begin
                // Verdict known: remaining bytes of the message are ignored.
            end
        endcase
    end

    // Clamp the running minimum to the floor, then to the cap.
    assign clamp_lo  = (min_ttl_next < ttl_floor_reg) ? ttl_floor_reg : min_ttl_next;
    assign clamp_min = (clamp_lo > ttl_cap_reg) ? ttl_cap_reg : clamp_lo;

    // Result for a message that ends on this byte.
    always_comb
    begin
        if (phase_next == PH_HEADER)
        begin
            res_ttl = fallback_reg;
            res_oc  = OC_SHORT_HDR;
        end
        else if (phase_next == PH_DONE_NX)
        begin
            res_ttl = nxdomain_reg;
            res_oc  = OC_NXDOMAIN;
        end
        else if (phase_next == PH_DONE_ER)
        begin
            res_ttl = '0;
            res_oc  = OC_NO_ANSWER;
        end
        else if (rec_open && !rec_done)
        begin
            res_ttl = fallback_reg;
            res_oc  = OC_TRUNCATED;
        end
        else
        begin
            res_ttl = clamp_min;
            res_oc  = OC_ANSWERS;
        end
    end

    // Parser state and the two-entry output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_index_reg <= '0;
            rcode_reg        <= '0;
            questions_reg    <= '0;
            answers_reg      <= '0;
            skip_reg         <= '0;
            fixed_index_reg  <= '0;
            record_ttl_reg   <= '0;
            min_ttl_reg      <= CAP_RESET;
            data_len_reg     <= '0;
            out_valid_reg    <= 1'b0;
            out_ttl_reg      <= '0;
            out_oc_reg       <= '0;
            skid_valid_reg   <= 1'b0;
            skid_ttl_reg     <= '0;
            skid_oc_reg      <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                if (last_byte)
                begin
                    // Message ends: start clean for the next one.
                    phase_reg        <= PH_HEADER;
                    header_index_reg <= '0;
                    rcode_reg        <= '0;
                    questions_reg    <= '0;
                    answers_reg      <= '0;
                    skip_reg         <= '0;
                    fixed_index_reg  <= '0;
                    record_ttl_reg   <= '0;
                    min_ttl_reg      <= ttl_cap_reg;
                    data_len_reg     <= '0;
                end
                else
                begin
                    phase_reg        <= phase_next;
                    header_index_reg <= header_index_next;
                    rcode_reg        <= rcode_next;
                    questions_reg    <= questions_next;
                    answers_reg      <= answers_next;
                    skip_reg         <= skip_next;
                    fixed_index_reg  <= fixed_index_next;
                    record_ttl_reg   <= record_ttl_next;
                    min_ttl_reg      <= min_ttl_next;
                    data_len_reg     <= data_len_next;
                end
            end

            // Output stage: the skid entry refills the output register first.
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    out_ttl_reg    <= skid_ttl_reg;
                    out_oc_reg     <= skid_oc_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (produce)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_reg <= 1'b1;
                    out_ttl_reg   <= res_ttl;
                    out_oc_reg    <= res_oc;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                    skid_ttl_reg   <= res_ttl;
                    skid_oc_reg    <= res_oc;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item with the output register empty");

    // The final byte of a message always returns the parser to the header.
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_byte) |=> (phase_reg == PH_HEADER && header_index_reg == 4'd0))
        else $error("parser did not restart after the final byte");

    // The header counter stops at the final header byte.
    a_header_bound: assert property (@(posedge clk) disable iff (!rst_n)
        header_index_reg <= HDR_LAST)
        else $error("header index ran past the header");

    // The fixed-part counter stays inside the ten record header bytes.
    a_fixed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fixed_index_reg <= FIX_LAST)
        else $error("fixed-part index ran past the record header");

    // Only defined result codes reach the output.
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_oc_reg <= OC_TRUNCATED))
        else $error("undefined outcome code on the output");

endmodule : dns_answer_min_ttl_scanner_unit

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for dns_answer_min_ttl_scanner_unit: streams DNS responses
// a byte at a time, predicts the cache TTL and outcome of each message and checks
// every result item in order. Depends on dnsttl_pkg and the scanner RTL.
`timescale 1ns / 100ps

module tb;

    import dnsttl_pkg::*;

    // Response codes used when building headers.
    localparam logic [3:0] RCODE_NOERROR  = 4'd0;
    localparam logic [3:0] RCODE_SERVFAIL = 4'd2;
    localparam logic [3:0] RCODE_REFUSED  = 4'd5;
    localparam logic [3:0] RCODE_RESERVED = 4'd15;

    // Parse phases of the predicted scanner.
    typedef enum logic [2:0] {
        ST_HDR,
        ST_QNAME,
        ST_ANAME,
        ST_AFIX,
        ST_ADATA,
        ST_OK,
        ST_NX,
        ST_ERR
    } scan_phase_t;

    // One expected result item.
    typedef struct {
        logic [TTL_W-1:0] ttl;
        logic [OC_W-1:0]  oc;
    } ttl_verdict_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] msg_byte;
    logic              last_byte;
    logic              out_valid;
    logic              out_ready;
    logic [TTL_W-1:0]  ttl_seconds;
    logic [OC_W-1:0]   outcome;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [TTL_W-1:0]  cfg_data;

    // Register copies held by the predictor.
    logic [TTL_W-1:0] reg_floor;
    logic [TTL_W-1:0] reg_cap;
    logic [TTL_W-1:0] reg_fallback;
    logic [TTL_W-1:0] reg_nxdomain;

    // Predicted parser state.
    scan_phase_t      phase;
    logic [3:0]       hdr_idx;
    logic [3:0]       rcode;
    logic [15:0]      qd_left;
    logic [15:0]      an_left;
    logic [15:0]      skip;
    logic [3:0]       fix_idx;
    logic [31:0]      rec_ttl;
    logic [TTL_W-1:0] min_seen;
    logic [15:0]      rd_len;

    ttl_verdict_t     verdicts_due[$];
    logic [7:0]       msg_q[$];
    int unsigned      err_count = 0;
    int unsigned      bytes_sent = 0;
    int unsigned      src_idle_pct = 38;
    int unsigned      sink_idle_pct = 38;

    dns_answer_min_ttl_scanner_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .msg_byte    (msg_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ttl_seconds (ttl_seconds),
        .outcome     (outcome),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 12 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bound on the whole run.
    initial
    begin
        #(5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        err_count++;
    endtask

    // Clears the per-message state, as at reset and after each final byte.
    function automatic void restart_scan();
        phase    = ST_HDR;
        hdr_idx  = '0;
        rcode    = '0;
        qd_left  = '0;
        an_left  = '0;
        skip     = '0;
        fix_idx  = '0;
        rec_ttl  = '0;
        rd_len   = '0;
        min_seen = reg_cap;
    endfunction

    // Advances the predicted parser by one accepted byte and, on the final
    // byte of a message, queues the TTL and outcome that the unit must give.
    task automatic parse_dns_byte(input logic [7:0] b, input logic is_last);
        bit               rec_open;
        bit               rec_done;
        logic [TTL_W-1:0] m;
        ttl_verdict_t     v;
        rec_open = 1'b0;
        rec_done = 1'b0;
        case (phase)
            ST_HDR:
            begin
                if (hdr_idx == HDR_RCODE)
                    rcode = b[3:0];
                else if (hdr_idx == HDR_QD_HI)
                    qd_left = {b, 8'h00};
                else if (hdr_idx == HDR_QD_LO)
                    qd_left = qd_left | {8'h00, b};
                else if (hdr_idx == HDR_AN_HI)
                    an_left = {b, 8'h00};
                else if (hdr_idx == HDR_AN_LO)
                    an_left = an_left | {8'h00, b};
                if (hdr_idx >= HDR_LAST)
                begin
                    min_seen = reg_cap;
                    skip     = '0;
                    if (rcode == RCODE_NXDOMAIN)
                        phase = ST_NX;
                    else if (rcode != RCODE_NOERROR || an_left == 0)
                        phase = ST_ERR;
                    else
                        phase = (qd_left != 0) ? ST_QNAME : ST_ANAME;
                end
                else
                    hdr_idx++;
            end
            ST_QNAME:
            begin
                if (skip != 0)
                begin
                    skip--;
                    if (skip == 0 && qd_left == 0)
                        phase = ST_ANAME;
                end
                else if (b == 8'h00)
                begin
                    qd_left--;
                    skip = QTAIL_SKIP;
                end
                else if (b[7:6] == PTR_MARK)
                begin
                    qd_left--;
                    skip = QTAIL_PTR_SKIP;
                end
                else
                    skip = {8'h00, b};
            end
            ST_ANAME:
            begin
                rec_open = 1'b1;
                if (skip != 0)
                    skip--;
                else if (b == 8'h00)
                begin
                    phase   = ST_AFIX;
                    fix_idx = '0;
                end
                else if (b[7:6] == PTR_MARK)
                begin
                    // The second pointer byte is skipped at the start of the fixed part.
                    skip    = 16'd1;
                    phase   = ST_AFIX;
                    fix_idx = '0;
                end
                else
                    skip = {8'h00, b};
            end
            ST_AFIX:
            begin
                rec_open = 1'b1;
                if (skip != 0)
                    skip--;
                else
                begin
                    if (fix_idx >= FIX_TTL_FIRST && fix_idx <= FIX_TTL_LAST)
                        rec_ttl = {rec_ttl[23:0], b};
                    else if (fix_idx >= FIX_LEN_FIRST)
                        rd_len = {rd_len[7:0], b};
                    if (fix_idx >= FIX_LAST)
                    begin
                        rec_done = 1'b1;
                        if (rec_ttl < {15'd0, min_seen})
                            min_seen = rec_ttl[TTL_W-1:0];
                        an_left--;
                        fix_idx = '0;
                        if (an_left == 0)
                        begin
                            phase = ST_OK;
                            skip  = '0;
                        end
                        else if (rd_len == 0)
                            phase = ST_ANAME;
                        else
                        begin
                            skip  = rd_len;
                            phase = ST_ADATA;
                        end
                    end
                    else
                        fix_idx++;
                end
            end
            ST_ADATA:
            begin
                if (skip != 0)
                    skip--;
                if (skip == 0)
                    phase = ST_ANAME;
            end
            default:
            begin
                // Verdict known: trailing bytes are ignored.
            end
        endcase

        if (is_last)
        begin
            if (phase == ST_HDR)
            begin
                v.ttl = reg_fallback;
                v.oc  = OC_SHORT_HDR;
            end
            else if (phase == ST_NX)
            begin
                v.ttl = reg_nxdomain;
                v.oc  = OC_NXDOMAIN;
            end
            else if (phase == ST_ERR)
            begin
                v.ttl = '0;
                v.oc  = OC_NO_ANSWER;
            end
            else if (rec_open && !rec_done)
            begin
                v.ttl = reg_fallback;
                v.oc  = OC_TRUNCATED;
            end
            else
            begin
                m = min_seen;
                if (m < reg_floor)
                    m = reg_floor;
                if (m > reg_cap)
                    m = reg_cap;
                v.ttl = m;
                v.oc  = OC_ANSWERS;
            end
            verdicts_due.push_back(v);
            restart_scan();
        end
    endtask

    // Sends one byte item, with random idle cycles ahead of it.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        msg_byte  <= b;
        last_byte <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        parse_dns_byte(b, is_last);
    endtask

    // Sends the built message, cut after the given number of bytes when that is nonzero.
    task automatic send_msg(input int unsigned cut);
        int unsigned n;
        n = (cut == 0 || cut > msg_q.size()) ? msg_q.size() : cut;
        for (int unsigned i = 0; i < n; i++)
            send_byte(msg_q[i], i == n - 1);
        msg_q.delete();
    endtask

    // Holds the input idle until every expected result has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all four TTL registers while the unit is idle.
    task automatic set_ttl_regs(input logic [TTL_W-1:0] floor_v, input logic [TTL_W-1:0] cap_v,
                                input logic [TTL_W-1:0] fb_v, input logic [TTL_W-1:0] nx_v);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_TTL_FLOOR;
        cfg_data  <= floor_v;
        @(posedge clk);
        cfg_index <= REG_TTL_CAP;
        cfg_data  <= cap_v;
        @(posedge clk);
        cfg_index <= REG_FALLBACK_TTL;
        cfg_data  <= fb_v;
        @(posedge clk);
        cfg_index <= REG_NXDOMAIN_TTL;
        cfg_data  <= nx_v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        reg_floor    = floor_v;
        reg_cap      = cap_v;
        reg_fallback = fb_v;
        reg_nxdomain = nx_v;
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_header(input logic [3:0] rc, input logic [15:0] qd,
                                       input logic [15:0] an);
        logic [3:0] flags_hi;
        flags_hi = 4'($urandom_range(0, 15));
        msg_q.push_back(rand_byte());
        msg_q.push_back(rand_byte());
        msg_q.push_back(rand_byte());
        msg_q.push_back({flags_hi, rc});
        msg_q.push_back(qd[15:8]);
        msg_q.push_back(qd[7:0]);
        msg_q.push_back(an[15:8]);
        msg_q.push_back(an[7:0]);
        repeat (4) msg_q.push_back(rand_byte());
    endfunction

    // A name of a few short labels, ended by the root label or a compression
    // pointer; a nonzero first_len forces a leading label of that length.
    function automatic void add_name(input bit ptr, input logic [7:0] first_len);
        int unsigned labels;
        logic [7:0]  len;
        logic [5:0]  offset;
        labels = $urandom_range(0, 3);
        if (first_len != 0)
            labels++;
        for (int unsigned i = 0; i < labels; i++)
        begin
            len = (i == 0 && first_len != 0) ? first_len : 8'($urandom_range(1, 6));
            msg_q.push_back(len);
            repeat (len) msg_q.push_back(rand_byte());
        end
        if (ptr)
        begin
            offset = 6'($urandom_range(0, 63));
            msg_q.push_back({PTR_MARK, offset});
            msg_q.push_back(rand_byte());
        end
        else
            msg_q.push_back(8'h00);
    endfunction

    function automatic void add_question(input bit ptr, input logic [7:0] first_len);
        add_name(ptr, first_len);
        repeat (4) msg_q.push_back(rand_byte());
    endfunction

    function automatic void add_answer(input bit ptr, input logic [31:0] ttl,
                                       input logic [15:0] rdlen);
        add_name(ptr, 8'd0);
        repeat (4) msg_q.push_back(rand_byte());
        msg_q.push_back(ttl[31:24]);
        msg_q.push_back(ttl[23:16]);
        msg_q.push_back(ttl[15:8]);
        msg_q.push_back(ttl[7:0]);
        msg_q.push_back(rdlen[15:8]);
        msg_q.push_back(rdlen[7:0]);
        repeat (rdlen) msg_q.push_back(rand_byte());
    endfunction

    // Mostly well-formed responses with random content; the rest are noise,
    // miscounted sections, trailing bytes or messages cut at a random point.
    task automatic random_message();
        int unsigned kind;
        int unsigned qd;
        int unsigned an;
        int unsigned body_an;
        logic [3:0]  rc;
        logic [31:0] ttl;
        logic [15:0] rdlen;
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 40)) msg_q.push_back(rand_byte());
            send_msg(0);
        end
        else
        begin
            if (kind < 82)
                rc = RCODE_NOERROR;
            else if (kind < 90)
                rc = RCODE_NXDOMAIN;
            else
                rc = 4'($urandom_range(0, 15));
            qd = $urandom_range(0, 2);
            an = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
            add_header(rc, 16'(qd), 16'(an));
            repeat (qd)
                add_question($urandom_range(2) == 0,
                             8'(($urandom_range(19) == 0) ? $urandom_range(64, 191) : 0));
            body_an = ($urandom_range(9) == 0) ? $urandom_range(0, an + 1) : an;
            repeat (body_an)
            begin
                case ($urandom_range(4))
                    0:       ttl = $urandom_range(0, 20);
                    1:       ttl = $urandom_range(0, 86400);
                    2:       ttl = $urandom;
                    3:       ttl = reg_floor + $urandom_range(0, 2) - 1;
                    default: ttl = reg_cap + $urandom_range(0, 2) - 1;
                endcase
                rdlen = 16'(($urandom_range(9) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(0, 8));
                add_answer($urandom_range(2) == 0, ttl, rdlen);
            end
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 8)) msg_q.push_back(rand_byte());
            send_msg(($urandom_range(99) < 20) ? $urandom_range(1, msg_q.size()) : 0);
        end
    endtask

    // Messages that end inside the 12-byte header.
    task automatic test_short_header();
        msg_q.push_back(8'h00);
        send_msg(0);
        repeat (11) msg_q.push_back(8'hFF);
        send_msg(0);
        repeat (3)
        begin
            repeat ($urandom_range(2, 10)) msg_q.push_back(rand_byte());
            send_msg(0);
        end
    endtask

    // Name error, other error codes and an empty answer section.
    task automatic test_response_codes();
        add_header(RCODE_NXDOMAIN, 16'd1, 16'd2);
        send_msg(0);
        add_header(RCODE_NXDOMAIN, 16'd0, 16'd0);
        repeat (20) msg_q.push_back(rand_byte());
        send_msg(0);
        add_header(RCODE_REFUSED, 16'd1, 16'd1);
        add_question(1'b0, 8'd0);
        add_answer(1'b0, 32'd300, 16'd4);
        send_msg(0);
        add_header(RCODE_RESERVED, 16'd0, 16'd1);
        send_msg(0);
        add_header(RCODE_SERVFAIL, 16'd0, 16'd1);
        add_answer(1'b1, 32'd40, 16'd0);
        send_msg(0);
        add_header(RCODE_NOERROR, 16'd1, 16'd0);
        add_question(1'b1, 8'd0);
        send_msg(0);
    endtask

    // Minimum tracking and clamping to the floor and the cap.
    task automatic test_clamp_limits();
        add_header(RCODE_NOERROR, 16'd1, 16'd3);
        add_question(1'b0, 8'd0);
        add_answer(1'b0, 32'd100, 16'd2);
        add_answer(1'b1, 32'd3, 16'd0);
        add_answer(1'b0, 32'hFFFF_FFFF, 16'd1);
        send_msg(0);
        add_header(RCODE_NOERROR, 16'd0, 16'd1);
        add_answer(1'b1, 32'hFFFF_FFFF, 16'd0);
        send_msg(0);
        add_header(RCODE_NOERROR, 16'd0, 16'd2);
        add_answer(1'b0, 32'd86399, 16'd3);
        add_answer(1'b0, 32'h0001_0000, 16'd0);
        send_msg(0);
        add_header(RCODE_NOERROR, 16'd0, 16'd2);
        add_answer(1'b0, 32'h8000_0005, 16'd1);
        add_answer(1'b1, 32'd0, 16'd2);
        send_msg(0);
    endtask

    // Compression pointers and label lengths with only one top bit set.
    task automatic test_name_forms();
        add_header(RCODE_NOERROR, 16'd3, 16'd2);
        add_question(1'b1, 8'd0);
        add_question(1'b0, 8'd70);
        add_question(1'b1, 8'd150);
        add_answer(1'b1, 32'd500, 16'd3);
        add_answer(1'b0, 32'd400, 16'd0);
        send_msg(0);
        add_header(RCODE_NOERROR, 16'd0, 16'd1);
        add_answer(1'b1, 32'd1234, 16'd0);
        send_msg(0);
    endtask

    // Messages that stop before the declared sections are complete.
    task automatic test_early_end();
        int unsigned mark;
        // Inside the question section.
        add_header(RCODE_NOERROR, 16'd2, 16'd1);
        add_question(1'b0, 8'd0);
        add_question(1'b1, 8'd0);
        add_answer(1'b0, 32'd700, 16'd2);
        send_msg(15);
        // On the first byte of a record's owner name.
        add_header(RCODE_NOERROR, 16'd0, 16'd3);
        add_answer(1'b0, 32'd900, 16'd2);
        mark = msg_q.size();
        add_answer(1'b0, 32'd800, 16'd0);
        send_msg(mark + 1);
        // Inside the fixed part of a record.
        add_header(RCODE_NOERROR, 16'd0, 16'd1);
        add_answer(1'b1, 32'd900, 16'd5);
        send_msg(msg_q.size() - 9);
        // Inside rdata.
        add_header(RCODE_NOERROR, 16'd0, 16'd2);
        add_answer(1'b0, 32'd40, 16'd6);
        send_msg(msg_q.size() - 2);
        // On the last fixed byte of a record that is not the final one.
        add_header(RCODE_NOERROR, 16'd0, 16'd2);
        add_answer(1'b0, 32'd25, 16'd4);
        send_msg(msg_q.size() - 4);
        // Between two records.
        add_header(RCODE_NOERROR, 16'd0, 16'd3);
        add_answer(1'b0, 32'd50, 16'd0);
        add_answer(1'b0, 32'd20, 16'd3);
        send_msg(0);
        // Largest counts and largest rdata length, all cut short.
        add_header(RCODE_NOERROR, 16'hFFFF, 16'hFFFF);
        add_question(1'b0, 8'd0);
        add_question(1'b1, 8'd0);
        send_msg(0);
        add_header(RCODE_NOERROR, 16'd0, 16'd2);
        add_answer(1'b0, 32'd77, 16'hFFFF);
        send_msg(msg_q.size() - 65500);
    endtask

    // Register extremes, floor above cap, zero cap, then back to reset values.
    task automatic test_register_settings();
        set_ttl_regs(17'd0, 17'h1FFFF, 17'h1FFFF, 17'd0);
        random_message();
        set_ttl_regs(17'd86400, 17'd86400, 17'd0, 17'd86400);
        random_message();
        set_ttl_regs(17'd500, 17'd100, 17'd7, 17'd9);
        random_message();
        set_ttl_regs(17'd0, 17'd0, 17'd1, 17'd2);
        random_message();
        set_ttl_regs(FLOOR_RESET, CAP_RESET, FALLBACK_RESET, NXDOMAIN_RESET);
    endtask

    // Dense results against a mostly stalled receiver fill the output stage.
    task automatic test_back_pressure();
        src_idle_pct  = 0;
        sink_idle_pct = 90;
        repeat (40)
        begin
            repeat ($urandom_range(1, 3)) msg_q.push_back(rand_byte());
            send_msg(0);
        end
        // The sender waits here for every outstanding result.
        drain();
        src_idle_pct  = 38;
        sink_idle_pct = 38;
    endtask

    // Random responses under new settings, opening with a stretch at full rate.
    task automatic test_random_traffic();
        int unsigned msgs;
        msgs = 0;
        set_ttl_regs(17'($urandom_range(0, 600)), 17'($urandom_range(100, 86400)),
                     17'($urandom_range(0, 86400)), 17'($urandom_range(0, 86400)));
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (bytes_sent < 1300 || msgs < 6)
        begin
            if (msgs == 4)
            begin
                src_idle_pct  = 38;
                sink_idle_pct = 38;
            end
            random_message();
            msgs++;
        end
    endtask

    // Result checker and receiver stalls.
    initial
    begin
        ttl_verdict_t want;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                    report_mismatch($sformatf("unexpected result: ttl %0d outcome %0d",
                                              ttl_seconds, outcome));
                else
                begin
                    want = verdicts_due.pop_front();
                    if (ttl_seconds !== want.ttl)
                        report_mismatch($sformatf("ttl_seconds %0d, expected %0d",
                                                  ttl_seconds, want.ttl));
                    if (outcome !== want.oc)
                        report_mismatch($sformatf("outcome %0d, expected %0d",
                                                  outcome, want.oc));
                end
            end
            out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Test sequence.
    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        msg_byte     <= '0;
        last_byte    <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_TTL_FLOOR;
        cfg_data     <= '0;
        reg_floor    = FLOOR_RESET;
        reg_cap      = CAP_RESET;
        reg_fallback = FALLBACK_RESET;
        reg_nxdomain = NXDOMAIN_RESET;
        restart_scan();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_header();
        test_response_codes();
        test_clamp_limits();
        test_name_forms();
        test_early_end();
        test_register_settings();
        test_back_pressure();
        test_random_traffic();

        drain();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
